FILE: rtl/cmf_pkg.sv
package cmf_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TAPS_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int TAP_BITS    = 16;
    localparam int TAP_COUNT_W = 9;
    localparam int TAP_INDEX_W = 8;
    localparam int OUT_W       = 32;
    localparam int FRAC_BITS   = 15;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

    // Input item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TAP    = 1'b1;

    // Correlation sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Controls from the sequencer to the complex MAC
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage

FILE: rtl/cmf_ram.sv
module cmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/cmf_cmac.sv
module cmf_cmac
    import cmf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_TAPS    = MAX_TAPS_DEF
) (
    input  logic                          clk,
    input  mac_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_BITS-1:0] x_re,
    input  logic signed [SAMPLE_BITS-1:0] x_im,
    input  logic signed [TAP_BITS-1:0]    h_re,
    input  logic signed [TAP_BITS-1:0]    h_im,
    output logic signed [OUT_W-1:0]       res_re,
    output logic signed [OUT_W-1:0]       res_im
);

    localparam int PROD_W = SAMPLE_BITS + TAP_BITS;
    localparam int ACC_W  = PROD_W + 2 + $clog2(MAX_TAPS);
    localparam int Q_W    = ACC_W - FRAC_BITS;
    localparam int EXT_W  = (Q_W > OUT_W) ? Q_W : OUT_W + 1;

    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(OUT_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(OUT_MIN);

    logic signed [PROD_W-1:0] p_rr_reg;
    logic signed [PROD_W-1:0] p_ii_reg;
    logic signed [PROD_W-1:0] p_ir_reg;
    logic signed [PROD_W-1:0] p_ri_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [ACC_W-1:0]  acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_next;

    // Round half up by the fraction bits, then clamp to the output range
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] v;
        logic signed [Q_W-1:0]   q;
        logic signed [EXT_W-1:0] qx;
        v  = a + RND;
        q  = Q_W'(v >>> FRAC_BITS);
        qx = EXT_W'(q);
        if (qx > SAT_HI)
        begin
            return OUT_MAX;
        end
        if (qx < SAT_LO)
        begin
            return OUT_MIN;
        end
        return OUT_W'(qx);
    endfunction

    // Register the four partial products of x * conj(h)
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_rr_reg <= x_re * h_re;
            p_ii_reg <= x_im * h_im;
            p_ir_reg <= x_im * h_re;
            p_ri_reg <= x_re * h_im;
        end
    end

    // Combine products into the running sums
    always_comb
    begin
        acc_re_next = acc_re_reg + ACC_W'(p_rr_reg) + ACC_W'(p_ii_reg);
        acc_im_next = acc_im_reg + ACC_W'(p_ir_reg) - ACC_W'(p_ri_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign res_re = round_sat(acc_re_reg);
    assign res_im = round_sat(acc_im_reg);

endmodule

FILE: rtl/complex_matched_filter_correlator.sv
// Complex matched-filter correlator.
// Input channel (in_valid / in_stall) carries either a tap write (mode = 1)
// or a complex sample (mode = 0). Output channel (out_valid / out_stall)
// carries one complex correlation per sample once tap_count samples are held.
// A tap write stores one Q1.15 tap and empties the sample history.
// tap_count is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, as the block does not enforce it. A tap
// write, or a sample that gives no result, leaves the block ready for the
// next item; after a sample that gives a result, the next item can be taken
// in the cycle in which out_valid rises. The single complex MAC handles one
// tap per cycle, reading one tap and one history entry per cycle from the
// two RAMs; the pipeline then drains and the rounded result is registered.
// in_stall is high while a correlation is in progress.
// A stalled result holds in the output register; the block still takes new
// items, and a finished correlation waits until the register frees up.
// Reset clears the sequencer, history pointer, fill count and output valid,
// and sets tap_count to 1; tap and history RAM contents are not cleared.
module complex_matched_filter_correlator
    import cmf_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int VAL_W      = (SAMPLE_BITS > TAP_BITS) ? SAMPLE_BITS : TAP_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [TAP_COUNT_W-1:0]        cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [TAP_INDEX_W-1:0]        tap_index,
    input  logic signed [VAL_W-1:0]       value_re,
    input  logic signed [VAL_W-1:0]       value_im,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_W-1:0]       out_re,
    output logic signed [OUT_W-1:0]       out_im
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int SUM_W = CNT_W + 1;

    state_t                   state_reg;
    state_t                   state_next;
    logic [TAP_COUNT_W-1:0]   tap_count_reg;
    logic [AW-1:0]            wp_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [AW-1:0]            k_reg;
    logic [AW-1:0]            p_reg;
    logic [AW-1:0]            m_last_reg;
    logic                     rd_v_reg;
    logic                     mul_v_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_re_reg;
    logic signed [OUT_W-1:0]  out_im_reg;

    logic                     accept;
    logic                     tap_in_range;
    logic                     tap_wr;
    logic                     smp_wr;
    logic                     go;
    logic                     issue;
    logic                     last_issue;
    logic                     out_free;
    logic                     load_out;
    logic [AW-1:0]            wp_inc;
    logic [CNT_W-1:0]         fill_inc;
    logic [31:0]              tc_ext;
    logic [CNT_W-1:0]         m_eff;
    logic [SUM_W-1:0]         wp_ext;
    logic [SUM_W-1:0]         m_ext;
    logic [SUM_W-1:0]         start_sum;
    logic [AW-1:0]            start;
    mac_ctrl_t                mac_ctrl;

    logic [2*TAP_BITS-1:0]    tap_rdata;
    logic [2*SAMPLE_BITS-1:0] hist_rdata;
    logic signed [OUT_W-1:0]  res_re;
    logic signed [OUT_W-1:0]  res_im;

    // Input transfer decode
    assign accept       = in_valid && !in_stall;
    assign tap_in_range = 32'(tap_index) < 32'(MAX_TAPS);
    assign tap_wr       = accept && (mode == MODE_TAP) && tap_in_range;
    assign smp_wr       = accept && (mode == MODE_SAMPLE);
    assign in_stall     = (state_reg != ST_IDLE);

    // Pointer and fill count after this sample
    assign wp_inc   = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign fill_inc = (fill_reg == CNT_W'(MAX_TAPS)) ? fill_reg : fill_reg + 1'b1;

    // Clamp the tap count to 1..MAX_TAPS
    always_comb
    begin
        tc_ext = 32'(tap_count_reg);
        if (tc_ext == 32'd0)
        begin
            m_eff = CNT_W'(1);
        end
        else if (tc_ext > 32'(MAX_TAPS))
        begin
            m_eff = CNT_W'(MAX_TAPS);
        end
        else
        begin
            m_eff = CNT_W'(tc_ext);
        end
    end

    // Oldest of the last M samples
    always_comb
    begin
        wp_ext = SUM_W'(wp_inc);
        m_ext  = SUM_W'(m_eff);
        if (wp_ext >= m_ext)
        begin
            start_sum = wp_ext - m_ext;
        end
        else
        begin
            start_sum = wp_ext + SUM_W'(MAX_TAPS) - m_ext;
        end
        start = start_sum[AW-1:0];
    end

    assign go         = smp_wr && (fill_inc >= m_eff);
    assign last_issue = (k_reg == m_last_reg);
    assign out_free   = !out_valid_reg || !out_stall;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !mul_v_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        issue           = 1'b0;
        load_out        = 1'b0;
        mac_ctrl.clear  = go;
        mac_ctrl.mul_en = rd_v_reg;
        mac_ctrl.acc_en = mul_v_reg;
        case (state_reg)
            ST_RUN:
            begin
                issue = 1'b1;
            end
            ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                issue    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_W'(1);
            wp_reg        <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            p_reg         <= '0;
            m_last_reg    <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;

            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end

            // Tap write empties the history; a sample advances it
            if (tap_wr)
            begin
                wp_reg   <= '0;
                fill_reg <= '0;
            end
            else if (smp_wr)
            begin
                wp_reg   <= wp_inc;
                fill_reg <= fill_inc;
            end

            // Load tap and history read pointers, then step them
            if (go)
            begin
                k_reg      <= '0;
                p_reg      <= start;
                m_last_reg <= AW'(m_eff - 1'b1);
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
                p_reg <= (p_reg == AW'(MAX_TAPS - 1)) ? '0 : p_reg + 1'b1;
            end

            // Output register valid
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_re_reg <= res_re;
            out_im_reg <= res_im;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;

    // Tap store: {imag, real} Q1.15
    cmf_ram #(
        .WIDTH (2 * TAP_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_wr),
        .waddr (AW'(tap_index)),
        .wdata ({value_im[TAP_BITS-1:0], value_re[TAP_BITS-1:0]}),
        .raddr (k_reg),
        .rdata (tap_rdata)
    );

    // Sample history ring: {imag, real}
    cmf_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (smp_wr),
        .waddr (wp_reg),
        .wdata ({value_im[SAMPLE_BITS-1:0], value_re[SAMPLE_BITS-1:0]}),
        .raddr (p_reg),
        .rdata (hist_rdata)
    );

    // Shared complex multiply-accumulate
    cmf_cmac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_cmac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .x_re   ($signed(hist_rdata[SAMPLE_BITS-1:0])),
        .x_im   ($signed(hist_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .h_re   ($signed(tap_rdata[TAP_BITS-1:0])),
        .h_im   ($signed(tap_rdata[2*TAP_BITS-1:TAP_BITS])),
        .res_re (res_re),
        .res_im (res_im)
    );

endmodule

FILE: rtl/cmf_checker.sv
module cmf_checker
    import cmf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    mode,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] out_re,
    input logic signed [OUT_W-1:0] out_im
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_re) && $stable(out_im))
        else $error("result changed while stalled");

    // A tap write transfer leaves the block ready for the next item
    a_tap_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == MODE_TAP) |=> !in_stall)
        else $error("busy after tap write");

    // A new result only follows a busy correlation cycle
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without correlation");

endmodule

bind complex_matched_filter_correlator cmf_checker u_cmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_re    (out_re),
    .out_im    (out_im)
);

FILE: test/tb_complex_matched_filter_correlator.sv
`timescale 1ns / 1ps

module tb_complex_matched_filter_correlator;
    import cmf_pkg::*;

    localparam int  TAPS       = MAX_TAPS_DEF;
    localparam int  VW         = TAP_BITS;
    localparam int  DRAIN_CYC  = TAPS + 8;
    localparam int  LONG_HOLD  = 200;
    localparam int  STOP_ITEMS = 1475;
    localparam int  CALM_ITEMS = 120;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    localparam logic signed [VW-1:0] V_MIN = 16'sh8000;
    localparam logic signed [VW-1:0] V_MAX = 16'sh7FFF;

    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } corr_t;

    // One row of the directed table: an item, or a tap-count write
    typedef struct {
        bit                      is_cfg;
        logic [TAP_COUNT_W-1:0]  cfg_val;
        logic                    m;
        logic [TAP_INDEX_W-1:0]  idx;
        logic signed [VW-1:0]    re;
        logic signed [VW-1:0]    im;
        bit                      typed;
        logic signed [OUT_W-1:0] xre;
        logic signed [OUT_W-1:0] xim;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [TAP_COUNT_W-1:0]  cfg_wdata;
    logic                    in_valid;
    logic                    in_stall;
    logic                    mode;
    logic [TAP_INDEX_W-1:0]  tap_index;
    logic signed [VW-1:0]    value_re;
    logic signed [VW-1:0]    value_im;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] out_re;
    logic signed [OUT_W-1:0] out_im;

    // Predictor state
    logic signed [VW-1:0]    coef_re [TAPS];
    logic signed [VW-1:0]    coef_im [TAPS];
    logic signed [VW-1:0]    samp_re [TAPS];
    logic signed [VW-1:0]    samp_im [TAPS];
    logic [TAP_INDEX_W-1:0]  samp_wr   = '0;
    int                      samp_fill = 0;
    logic [TAP_COUNT_W-1:0]  taps_cfg  = 9'd1;

    corr_t corr_due [$];
    row_t  dir_tbl [$];
    int    mismatch_cnt = 0;
    int    item_cnt     = 0;
    bit    calm         = 1'b0;
    bit    quiet        = 1'b0;
    bit    hold_req     = 1'b0;

    complex_matched_filter_correlator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .tap_index (tap_index),
        .value_re  (value_re),
        .value_im  (value_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_re    (out_re),
        .out_im    (out_im)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_complex_matched_filter_correlator: errors");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    // Append one row to the directed table
    task automatic add_row(input row_t r);
        dir_tbl = {dir_tbl, r};
    endtask

    function automatic int eff_taps(input logic [TAP_COUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > TAPS)
            return TAPS;
        return int'(v);
    endfunction

    function automatic logic signed [OUT_W-1:0] round_q15(input longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> FRAC_BITS;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[OUT_W-1:0];
    endfunction

    // Advance the predictor by one item; got is set when a result is due
    task automatic correlate_item(input logic m, input logic [TAP_INDEX_W-1:0] idx,
                                  input logic signed [VW-1:0] vr,
                                  input logic signed [VW-1:0] vi,
                                  output bit got, output corr_t res);
        int     eff;
        int     start;
        int     p;
        longint acc_re;
        longint acc_im;
        got    = 1'b0;
        res.re = '0;
        res.im = '0;
        acc_re = 0;
        acc_im = 0;
        if (m == MODE_TAP)
        begin
            coef_re[idx] = vr;
            coef_im[idx] = vi;
            samp_wr      = '0;
            samp_fill    = 0;
        end
        else
        begin
            samp_re[samp_wr] = vr;
            samp_im[samp_wr] = vi;
            samp_wr = samp_wr + 1'b1;
            if (samp_fill < TAPS)
                samp_fill++;
            eff = eff_taps(taps_cfg);
            if (samp_fill >= eff)
            begin
                start = (int'(samp_wr) + TAPS - eff) % TAPS;
                for (int k = 0; k < eff; k++)
                begin
                    p = (start + k) % TAPS;
                    acc_re += longint'(samp_re[p]) * longint'(coef_re[k])
                            + longint'(samp_im[p]) * longint'(coef_im[k]);
                    acc_im += longint'(samp_im[p]) * longint'(coef_re[k])
                            - longint'(samp_re[p]) * longint'(coef_im[k]);
                end
                res.re = round_q15(acc_re);
                res.im = round_q15(acc_im);
                got    = 1'b1;
            end
        end
    endtask

    // Offer one item, hold it until the transfer, then queue its result
    task automatic push_item(input logic m, input logic [TAP_INDEX_W-1:0] idx,
                             input logic signed [VW-1:0] vr,
                             input logic signed [VW-1:0] vi,
                             input bit typed, input logic signed [OUT_W-1:0] xre,
                             input logic signed [OUT_W-1:0] xim);
        bit    got;
        corr_t res;
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        tap_index <= idx;
        value_re  <= vr;
        value_im  <= vi;
        do
            @(posedge clk);
        while (in_stall);
        item_cnt++;
        correlate_item(m, idx, vr, vi, got, res);
        if (typed)
        begin
            res.re = xre;
            res.im = xim;
            got    = 1'b1;
        end
        if (got)
            corr_due = {corr_due, res};
    endtask

    // Drop valid, then wait on the clock until every result is in
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (corr_due.size() != 0);
    endtask

    // Write the tap count only once the block has gone idle
    task automatic set_tap_count(input logic [TAP_COUNT_W-1:0] v);
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        taps_cfg  = v;
    endtask

    function automatic logic signed [VW-1:0] pick_val();
        case ($urandom_range(0, 9))
            0: return V_MIN;
            1: return V_MAX;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return VW'($urandom());
        endcase
    endfunction

    function automatic row_t tap_row(input logic [TAP_INDEX_W-1:0] idx,
                                     input logic signed [VW-1:0] vr,
                                     input logic signed [VW-1:0] vi);
        row_t r;
        r = '{1'b0, 9'd0, MODE_TAP, idx, vr, vi, 1'b0, 32'sd0, 32'sd0};
        return r;
    endfunction

    function automatic row_t smp_row(input logic signed [VW-1:0] vr,
                                     input logic signed [VW-1:0] vi);
        row_t r;
        r = '{1'b0, 9'd0, MODE_SAMPLE, 8'd0, vr, vi, 1'b0, 32'sd0, 32'sd0};
        return r;
    endfunction

    function automatic row_t chk_row(input logic signed [VW-1:0] vr,
                                     input logic signed [VW-1:0] vi,
                                     input logic signed [OUT_W-1:0] xre,
                                     input logic signed [OUT_W-1:0] xim);
        row_t r;
        r = '{1'b0, 9'd0, MODE_SAMPLE, 8'd0, vr, vi, 1'b1, xre, xim};
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [TAP_COUNT_W-1:0] v);
        row_t r;
        r = '{1'b1, v, MODE_SAMPLE, 8'd0, 16'sd0, 16'sd0, 1'b0, 32'sd0, 32'sd0};
        return r;
    endfunction

    // Result side: check each transfer, then pick the next stall level
    initial
    begin
        corr_t exp_c;
        int    stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (corr_due.size() == 0)
                    flag_mismatch($sformatf("unexpected result re=%0d im=%0d", out_re, out_im));
                else
                begin
                    exp_c = corr_due.pop_front();
                    if (out_re !== exp_c.re)
                        flag_mismatch($sformatf("out_re %0d, want %0d", out_re, exp_c.re));
                    if (out_im !== exp_c.im)
                        flag_mismatch($sformatf("out_im %0d, want %0d", out_im, exp_c.im));
                end
            end
            if (hold_req)
            begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!calm && !quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 4) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int                     plen;
        int                     sel;
        logic [TAP_COUNT_W-1:0] tc;
        row_t                   r;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        mode      <= MODE_SAMPLE;
        tap_index <= '0;
        value_re  <= '0;
        value_im  <= '0;

        // Tap of -1 negates the sample; tap of -j swaps and negates
        add_row(tap_row(8'd0, V_MIN, 16'sd0));
        add_row(chk_row(16'sd5, -16'sd7, -32'sd5, 32'sd7));
        add_row(chk_row(V_MIN, V_MIN, 32'sd32768, 32'sd32768));
        add_row(chk_row(V_MAX, V_MAX, -32'sd32767, -32'sd32767));
        add_row(tap_row(8'd0, 16'sd0, V_MIN));
        add_row(chk_row(16'sd3, 16'sd9, -32'sd9, 32'sd3));
        add_row(chk_row(V_MAX, V_MIN, 32'sd32768, 32'sd32767));
        // Half tap: exact halves round upward
        add_row(tap_row(8'd0, 16'sd16384, 16'sd0));
        add_row(chk_row(16'sd1, -16'sd1, 32'sd1, 32'sd0));
        add_row(chk_row(16'sd0, 16'sd0, 32'sd0, 32'sd0));
        // Tap writes clear the history; then a longer filter fills up
        add_row(tap_row(8'd1, V_MAX, V_MAX));
        add_row(tap_row(8'd255, -16'sd1, -16'sd1));
        add_row(cfg_row(9'd2));
        add_row(smp_row(16'sd100, 16'sd200));
        add_row(smp_row(V_MIN, V_MAX));
        add_row(smp_row(V_MAX, V_MIN));
        // Zero count acts as one, history kept across the change
        add_row(cfg_row(9'd0));
        add_row(smp_row(16'sd7, 16'sd8));
        add_row(tap_row(8'd2, -16'sd1, 16'sd1));
        add_row(cfg_row(9'd3));
        add_row(smp_row(-16'sd5, 16'sd12));
        add_row(smp_row(16'sd1000, -16'sd1000));
        add_row(smp_row(V_MIN, V_MIN));
        add_row(cfg_row(9'd1));
        add_row(smp_row(16'sd42, -16'sd42));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_tbl[i])
        begin
            r = dir_tbl[i];
            if (r.is_cfg)
                set_tap_count(r.cfg_val);
            else
                push_item(r.m, r.idx, r.re, r.im, r.typed, r.xre, r.xim);
        end

        // Load every tap, then run the full-length filter
        for (int i = 0; i < TAPS; i++)
            push_item(MODE_TAP, TAP_INDEX_W'(i), VW'($urandom()), VW'($urandom()),
                      1'b0, 32'sd0, 32'sd0);
        set_tap_count(9'(TAPS));
        for (int i = 0; i < TAPS + 12; i++)
            push_item(MODE_SAMPLE, TAP_INDEX_W'($urandom()), pick_val(), pick_val(),
                      1'b0, 32'sd0, 32'sd0);
        // Above the maximum acts as the maximum
        set_tap_count(9'h1FF);
        for (int i = 0; i < 6; i++)
            push_item(MODE_SAMPLE, TAP_INDEX_W'($urandom()), pick_val(), pick_val(),
                      1'b0, 32'sd0, 32'sd0);

        // Short filters with random content, a few tap rewrites mixed in
        for (int phase = 0; item_cnt < STOP_ITEMS; phase++)
        begin
            sel = $urandom_range(0, 19);
            if (phase == 2)
                tc = 9'd4;
            else if (sel < 13)
                tc = 9'($urandom_range(1, 8));
            else if (sel < 17)
                tc = 9'($urandom_range(9, 32));
            else if (sel < 18)
                tc = 9'd0;
            else
                tc = 9'($urandom_range(33, 64));
            set_tap_count(tc);
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2)
                hold_req = 1'b1;
            plen = $urandom_range(20, 60);
            for (int j = 0; j < plen && item_cnt < STOP_ITEMS; j++)
            begin
                if (item_cnt >= STOP_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                if (phase == 4 && j == plen / 2)
                    wait_drained();
                if ($urandom_range(0, 24) == 0)
                    push_item(MODE_TAP, TAP_INDEX_W'($urandom()), pick_val(), pick_val(),
                              1'b0, 32'sd0, 32'sd0);
                else
                    push_item(MODE_SAMPLE, TAP_INDEX_W'($urandom()), pick_val(), pick_val(),
                              1'b0, 32'sd0, 32'sd0);
            end
        end

        // Drain and let any stray result show up
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatch_cnt == 0 && corr_due.size() == 0)
            $display("tb_complex_matched_filter_correlator: clean");
        else
            $display("tb_complex_matched_filter_correlator: errors");
        $finish;
    end

endmodule
